// File: rtl/rprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_pkg
// Shared types, constants and helpers of the retransmit tracker: command and
// result codes, controller-to-datapath command and status structs, delay math.
// ----------------------------------------------------------------------------
package rprt_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 32;
	localparam int unsigned RESULT_CAP      = 32;

	localparam int unsigned SEQ_W    = 32;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned RETRY_W  = 2;
	localparam int unsigned DLY_W    = 16;
	localparam int unsigned LIM_W    = 6;
	localparam int unsigned ENTRY_W  = SEQ_W + TIME_W + RETRY_W;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [DLY_W-1:0] PING_RST       = 16'd50;
	localparam logic [DLY_W-1:0] MIN_DLY_RST    = 16'd250;
	localparam logic [DLY_W-1:0] MAX_DLY_RST    = 16'd5000;
	localparam logic [LIM_W-1:0] MAX_RESEND_RST = 6'd32;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_SCAN   = 2'd2
	} cmd_code_t;

	typedef enum logic [2:0] {
		KIND_ACKED    = 3'd0,
		KIND_UNKNOWN  = 3'd1,
		KIND_RECORDED = 3'd2,
		KIND_FULL     = 3'd3,
		KIND_RESEND   = 3'd4,
		KIND_NONE_DUE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		REG_PING       = 2'd0,
		REG_MIN_DLY    = 2'd1,
		REG_MAX_DLY    = 2'd2,
		REG_MAX_RESEND = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_APPEND,
		WR_UPDATE,
		WR_SHIFT
	} wr_op_t;

	typedef enum logic [1:0] {
		OUT_SRC_IN,
		OUT_SRC_PEND,
		OUT_SRC_ZERO
	} out_src_t;

	typedef struct packed {
		logic     capture;
		logic     rd_first;
		logic     rd_next;
		wr_op_t   wr_op;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     scan_init;
		logic     pend_load;
		logic     n_inc;
		logic     out_push;
		out_src_t out_src;
		kind_t    out_kind;
		logic     out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic last_idx;
		logic match;
		logic due;
		logic limit_zero;
		logic limit_next;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

	// clamp to [lo, hi]; hi wins when the bounds are inverted
	function automatic logic [DLY_W-1:0] clamp_delay(input logic [19:0] x,
			input logic [DLY_W-1:0] lo, input logic [DLY_W-1:0] hi);
		logic [19:0] t;
		t = (x < {4'd0, lo}) ? {4'd0, lo} : x;
		return (t > {4'd0, hi}) ? hi : t[DLY_W-1:0];
	endfunction

	function automatic logic [RETRY_W-1:0] retry_inc(input logic [RETRY_W-1:0] r);
		return (r == 2'd3) ? r : r + 2'd1;
	endfunction

endpackage

// File: rtl/rprt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rprt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/rprt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_ctrl
// Controller of the retransmit tracker: sequences record, ack search and
// shift, and the table timeout scan: one entry per cycle unless results stall.
// ----------------------------------------------------------------------------
module rprt_ctrl
	import rprt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REC,
		ST_ACK_PRIME,
		ST_ACK_CMP,
		ST_SHIFT,
		ST_ACK_HIT,
		ST_ACK_MISS,
		ST_SCAN_PRIME,
		ST_SCAN_EVAL,
		ST_SCAN_END
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (command)
						CMD_RECORD: state_d = ST_REC;
						CMD_ACK:    state_d = ST_ACK_PRIME;
						CMD_SCAN:   state_d = ST_SCAN_PRIME;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_REC: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					cmd.out_src  = OUT_SRC_IN;
					cmd.out_last = 1'b1;
					if (stat.full) begin
						cmd.out_kind = KIND_FULL;
					end else begin
						cmd.out_kind = KIND_RECORDED;
						cmd.wr_op    = WR_APPEND;
						cmd.cnt_inc  = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_ACK_PRIME: begin
				if (stat.cnt_zero) begin
					state_d = ST_ACK_MISS;
				end else begin
					cmd.rd_first = 1'b1;
					state_d = ST_ACK_CMP;
				end
			end
			ST_ACK_CMP: begin
				if (stat.match) begin
					if (stat.last_idx) begin
						state_d = ST_ACK_HIT;
					end else begin
						cmd.rd_next = 1'b1;
						state_d = ST_SHIFT;
					end
				end else if (stat.last_idx) begin
					state_d = ST_ACK_MISS;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			ST_SHIFT: begin
				// move the entry just read one place toward the head
				cmd.wr_op = WR_SHIFT;
				if (stat.last_idx) begin
					state_d = ST_ACK_HIT;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			ST_ACK_HIT: begin
				if (stat.out_free) begin
					cmd.cnt_dec  = 1'b1;
					cmd.out_push = 1'b1;
					cmd.out_src  = OUT_SRC_IN;
					cmd.out_kind = KIND_ACKED;
					cmd.out_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ACK_MISS: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					cmd.out_src  = OUT_SRC_IN;
					cmd.out_kind = KIND_UNKNOWN;
					cmd.out_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_PRIME: begin
				cmd.scan_init = 1'b1;
				if (stat.cnt_zero || stat.limit_zero) begin
					state_d = ST_SCAN_END;
				end else begin
					cmd.rd_first = 1'b1;
					state_d = ST_SCAN_EVAL;
				end
			end
			ST_SCAN_EVAL: begin
				if (stat.due) begin
					// the previous resend is held back until we know it is not the last
					if (!stat.pend_valid || stat.out_free) begin
						if (stat.pend_valid) begin
							cmd.out_push = 1'b1;
							cmd.out_src  = OUT_SRC_PEND;
							cmd.out_kind = KIND_RESEND;
						end
						cmd.wr_op     = WR_UPDATE;
						cmd.pend_load = 1'b1;
						cmd.n_inc     = 1'b1;
						if (stat.limit_next || stat.last_idx) begin
							state_d = ST_SCAN_END;
						end else begin
							cmd.rd_next = 1'b1;
						end
					end
				end else if (stat.last_idx) begin
					state_d = ST_SCAN_END;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			ST_SCAN_END: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					cmd.out_last = 1'b1;
					if (stat.pend_valid) begin
						cmd.out_src  = OUT_SRC_PEND;
						cmd.out_kind = KIND_RESEND;
					end else begin
						cmd.out_src  = OUT_SRC_ZERO;
						cmd.out_kind = KIND_NONE_DUE;
					end
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: rtl/rprt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rprt_dp
// Datapath of the retransmit tracker: entry table RAM, walk index, entry
// count, resend delays, pending resend and the result register.
// ----------------------------------------------------------------------------
module rprt_dp
	import rprt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic [SEQ_W-1:0]  seq_no,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [DLY_W-1:0]  ping_ms,
	input  logic [DLY_W-1:0]  min_delay_ms,
	input  logic [DLY_W-1:0]  max_delay_ms,
	input  logic [LIM_W-1:0]  limit,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SEQ_W-1:0]  out_seq,
	output logic [2:0]        kind,
	output logic              last
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [SEQ_W-1:0]   in_seq_q;
	logic [TIME_W-1:0]  in_now_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      idx_inc;
	logic [CW-1:0]      idx_dec;
	logic [LIM_W-1:0]   n_q;
	logic               pend_valid_q;
	logic [SEQ_W-1:0]   pend_seq_q;
	logic [DLY_W-1:0]   dly0_q, dly1_q, dly2_q;
	logic [DLY_W-1:0]   dly_sel;
	logic [TIME_W-1:0]  elapsed;

	logic               out_valid_q;
	logic [SEQ_W-1:0]   out_seq_q;
	kind_t              kind_q;
	logic               last_q;
	logic               out_free;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [SEQ_W-1:0]   rd_seq;
	logic [TIME_W-1:0]  rd_sent;
	logic [RETRY_W-1:0] rd_retries;

	assign idx_inc = idx_q + CW'(1);
	assign idx_dec = idx_q - CW'(1);
	assign {rd_seq, rd_sent, rd_retries} = rd_data;

	// read address follows the walk so the read register always holds entry idx_q
	always_comb begin
		if (cmd.rd_first) begin
			rd_addr = '0;
		end else if (cmd.rd_next) begin
			rd_addr = idx_inc[AW-1:0];
		end else begin
			rd_addr = idx_q[AW-1:0];
		end
	end

	always_comb begin
		wr_en = (cmd.wr_op != WR_NONE);
		case (cmd.wr_op)
			WR_APPEND: begin
				wr_addr = cnt_q[AW-1:0];
				wr_data = {in_seq_q, in_now_q, {RETRY_W{1'b0}}};
			end
			WR_UPDATE: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = {rd_seq, in_now_q, retry_inc(rd_retries)};
			end
			WR_SHIFT: begin
				wr_addr = idx_dec[AW-1:0];
				wr_data = rd_data;
			end
			default: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_data;
			end
		endcase
	end

	rprt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		case (rd_retries)
			2'd0:    dly_sel = dly0_q;
			2'd1:    dly_sel = dly1_q;
			default: dly_sel = dly2_q;
		endcase
	end

	assign elapsed  = in_now_q - rd_sent;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		stat.cnt_zero   = (cnt_q == '0);
		stat.full       = (cnt_q == CW'(TABLE_DEPTH));
		stat.last_idx   = (idx_inc == cnt_q);
		stat.match      = (rd_seq == in_seq_q);
		stat.due        = (elapsed > {{(TIME_W-DLY_W){1'b0}}, dly_sel});
		stat.limit_zero = (limit == '0);
		stat.limit_next = ({1'b0, n_q} + (LIM_W+1)'(1)) >= {1'b0, limit};
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.rd_first) begin
				idx_q <= '0;
			end else if (cmd.rd_next) begin
				idx_q <= idx_inc;
			end
			if (cmd.scan_init) begin
				n_q          <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (cmd.n_inc) begin
					n_q <= n_q + LIM_W'(1);
				end
				if (cmd.pend_load) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_seq_q <= seq_no;
			in_now_q <= now_ms;
		end
		if (cmd.scan_init) begin
			dly0_q <= clamp_delay({ping_ms, 4'b0000}, min_delay_ms, max_delay_ms);
			dly1_q <= clamp_delay({1'b0, ping_ms, 3'b000}, min_delay_ms, max_delay_ms);
			dly2_q <= clamp_delay({2'b00, ping_ms, 2'b00}, min_delay_ms, max_delay_ms);
		end
		if (cmd.pend_load) begin
			pend_seq_q <= rd_seq;
		end
		if (cmd.out_push) begin
			case (cmd.out_src)
				OUT_SRC_IN:   out_seq_q <= in_seq_q;
				OUT_SRC_PEND: out_seq_q <= pend_seq_q;
				default:      out_seq_q <= '0;
			endcase
			kind_q <= cmd.out_kind;
			last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_seq   = out_seq_q;
	assign kind      = kind_q;
	assign last      = last_q;

`ifndef SYNTH
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_push |-> out_free)
		else $error("result pushed over an item not yet taken");

	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (cnt_q != CW'(TABLE_DEPTH)))
		else $error("append into a full table");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_op == WR_UPDATE || cmd.wr_op == WR_SHIFT) |-> (idx_q < cnt_q))
		else $error("entry write outside the live table");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> (idx_inc < cnt_q))
		else $error("walk stepped past the last entry");
`endif

endmodule

// File: rtl/reliable_packet_retransmit_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_packet_retransmit_tracker_core
// Ordered table of unacknowledged packets with record, ack and timeout scan.
// ----------------------------------------------------------------------------
// The table lives in a single-port-read RAM and every command that looks at
// it walks the live entries one per cycle; a stalled result port can hold a
// scan. An ack searches up to the match, then moves every later entry one
// place up. A scan examines entries until the table end or the per-scan
// resend limit is reached. A stalled result port also holds a command on
// its final result. Only one item is worked on at a time, and the next item
// is taken as soon as the last result of the current one sits in the output
// register.
module reliable_packet_retransmit_tracker_core
	import rprt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [SEQ_W-1:0]   seq_no,
	input  logic [TIME_W-1:0]  now_ms,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [SEQ_W-1:0]   out_seq,
	output logic [2:0]         kind,
	output logic               last,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [DLY_W-1:0] ping_ms_q;
	logic [DLY_W-1:0] min_delay_ms_q;
	logic [DLY_W-1:0] max_delay_ms_q;
	logic [LIM_W-1:0] max_resend_q;
	logic [LIM_W-1:0] limit;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_ms_q      <= PING_RST;
			min_delay_ms_q <= MIN_DLY_RST;
			max_delay_ms_q <= MAX_DLY_RST;
			max_resend_q   <= MAX_RESEND_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PING:       ping_ms_q      <= pwdata[DLY_W-1:0];
				REG_MIN_DLY:    min_delay_ms_q <= pwdata[DLY_W-1:0];
				REG_MAX_DLY:    max_delay_ms_q <= pwdata[DLY_W-1:0];
				REG_MAX_RESEND: max_resend_q   <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PING:       prdata = {{(PDATA_W-DLY_W){1'b0}}, ping_ms_q};
			REG_MIN_DLY:    prdata = {{(PDATA_W-DLY_W){1'b0}}, min_delay_ms_q};
			REG_MAX_DLY:    prdata = {{(PDATA_W-DLY_W){1'b0}}, max_delay_ms_q};
			REG_MAX_RESEND: prdata = {{(PDATA_W-LIM_W){1'b0}}, max_resend_q};
			default:        prdata = '0;
		endcase
	end

	// resends per scan never exceed the result capacity
	assign limit = (max_resend_q > LIM_W'(RESULT_CAP)) ? LIM_W'(RESULT_CAP) : max_resend_q;

	rprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	rprt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.seq_no       (seq_no),
		.now_ms       (now_ms),
		.ping_ms      (ping_ms_q),
		.min_delay_ms (min_delay_ms_q),
		.max_delay_ms (max_delay_ms_q),
		.limit        (limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_seq      (out_seq),
		.kind         (kind),
		.last         (last)
	);

endmodule

// File: test/tb_reliable_packet_retransmit_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reliable_packet_retransmit_tracker_core
// Self-checking bench for the retransmit timer table. A short table of
// directed items hits an empty table, duplicates, misses, wrapped time
// and idle scans. Then random record, ack and scan traffic runs under several
// register settings, including zero delay, the largest delay, inverted clamps
// and scan limits of 0, 1 and above 32. Every accepted item runs through a
// local model of the table, and each result is matched against it in order.
// ----------------------------------------------------------------------------
module tb_reliable_packet_retransmit_tracker_core;
	import rprt_pkg::*;

	localparam int unsigned TBL_DEPTH   = TABLE_DEPTH_DEF;
	localparam int          PHASE_ITEMS = 40;
	localparam int          IDLE_TAIL   = 80;
	localparam int          DIR_ROWS    = 20;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;

	typedef struct packed {
		logic [31:0] seq;
		logic [2:0]  kind;
		logic        last;
	} res_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] seq;
		logic [31:0] tnow;
		bit          typed;
		logic [2:0]  tkind;
		logic [31:0] tseq;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         command = CMD_RECORD;
	logic [SEQ_W-1:0]   seq_no = '0;
	logic [TIME_W-1:0]  now_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SEQ_W-1:0]   out_seq;
	logic [2:0]         kind;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	reliable_packet_retransmit_tracker_core #(
		.TABLE_DEPTH(TBL_DEPTH)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .seq_no(seq_no), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_seq(out_seq), .kind(kind), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the packet table and registers
	logic [31:0] tbl_seq [TBL_DEPTH];
	logic [31:0] tbl_sent [TBL_DEPTH];
	logic [1:0]  tbl_tries [TBL_DEPTH];
	int          tbl_count = 0;
	logic [15:0] cfg_ping = PING_RST;
	logic [15:0] cfg_min = MIN_DLY_RST;
	logic [15:0] cfg_max = MAX_DLY_RST;
	logic [5:0]  cfg_limit = MAX_RESEND_RST;

	res_t        step_results[$];
	res_t        pending_results[$];
	int          mismatches = 0;
	int          cmd_seen [4] = '{0, 0, 0, 0};
	int          kind_seen [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
	int          items_sent = 0;
	int          gap_burst = 0;
	int          stall_hold = 0;
	int          stall_pick;
	logic [31:0] cur_now = 32'd0;
	dir_row_t    dir_tab [DIR_ROWS];

	function automatic void note_step(input res_t r);
		step_results.insert(step_results.size(), r);
	endfunction

	function automatic void note_pending(input res_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic logic [31:0] resend_wait(input logic [1:0] tries);
		logic [31:0] d;
		d = {16'd0, cfg_ping} << 2;
		if (tries == 2'd0)
			d = d << 2;
		else if (tries == 2'd1)
			d = d << 1;
		if (d < {16'd0, cfg_min})
			d = {16'd0, cfg_min};
		if (d > {16'd0, cfg_max})
			d = {16'd0, cfg_max};
		return d;
	endfunction

	// applies one item to the table copy, leaves its results in step_results
	function automatic void track_packets(input logic [1:0] cmd, input logic [31:0] seq,
			input logic [31:0] tnow);
		int i;
		int j;
		int n;
		int lim;
		bit hit;
		step_results.delete();
		case (cmd)
			CMD_RECORD: begin
				if (tbl_count >= TBL_DEPTH) begin
					note_step('{seq, KIND_FULL, 1'b1});
				end else begin
					tbl_seq[tbl_count] = seq;
					tbl_sent[tbl_count] = tnow;
					tbl_tries[tbl_count] = 2'd0;
					tbl_count++;
					note_step('{seq, KIND_RECORDED, 1'b1});
				end
			end
			CMD_ACK: begin
				hit = 1'b0;
				for (i = 0; i < tbl_count && !hit; i++) begin
					if (tbl_seq[i] == seq) begin
						hit = 1'b1;
						for (j = i; j + 1 < tbl_count; j++) begin
							tbl_seq[j] = tbl_seq[j+1];
							tbl_sent[j] = tbl_sent[j+1];
							tbl_tries[j] = tbl_tries[j+1];
						end
						tbl_count--;
					end
				end
				note_step('{seq, hit ? KIND_ACKED : KIND_UNKNOWN, 1'b1});
			end
			CMD_SCAN: begin
				lim = (cfg_limit > 6'd32) ? 32 : int'(cfg_limit);
				n = 0;
				for (i = 0; i < tbl_count; i++) begin
					if (n >= lim)
						break;
					if (tnow - tbl_sent[i] > resend_wait(tbl_tries[i])) begin
						tbl_sent[i] = tnow;
						if (tbl_tries[i] != 2'd3)
							tbl_tries[i] = tbl_tries[i] + 2'd1;
						note_step('{tbl_seq[i], KIND_RESEND, 1'b0});
						n++;
					end
				end
				if (n == 0)
					note_step('{32'd0, KIND_NONE_DUE, 1'b1});
				else
					step_results[n-1].last = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	// mostly back-to-back bursts and short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (gap_burst > 0) begin
			gap_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 30) begin
			gap_burst = $urandom_range(5, 20);
			return 0;
		end
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void advance_now();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			cur_now = cur_now + $urandom_range(0, 300);
		else if (r < 90)
			cur_now = cur_now + $urandom_range(300, 3000);
		else if (r < 98)
			cur_now = cur_now + $urandom_range(3000, 70000);
		else
			cur_now = $urandom();
	endfunction

	task automatic send_item(input logic [1:0] cmd, input logic [31:0] seq,
			input logic [31:0] tnow, input bit typed, input res_t typed_res);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		seq_no <= seq;
		now_ms <= tnow;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_packets(cmd, seq, tnow);
		if (typed)
			note_pending(typed_res);
		else
			foreach (step_results[k])
				note_pending(step_results[k]);
		cmd_seen[cmd]++;
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic random_item();
		logic [1:0]  cmd;
		logic [31:0] seq;
		int          r;
		advance_now();
		r = $urandom_range(0, 99);
		seq = $urandom();
		if (r < 35) begin
			cmd = CMD_RECORD;
			if (tbl_count > 0 && $urandom_range(0, 6) == 0)
				seq = tbl_seq[$urandom_range(0, tbl_count - 1)];
		end else if (r < 65) begin
			cmd = CMD_ACK;
			if (tbl_count > 0 && $urandom_range(0, 3) != 0)
				seq = tbl_seq[$urandom_range(0, tbl_count - 1)];
		end else if (r < 95) begin
			cmd = CMD_SCAN;
		end else begin
			cmd = CMD_UNUSED;
		end
		send_item(cmd, seq, cur_now, 1'b0, '0);
	endtask

	// records until the table is full, then two more that must bounce
	task automatic fill_table();
		int n;
		n = TBL_DEPTH - tbl_count + 2;
		repeat (n) begin
			cur_now = cur_now + $urandom_range(0, 20);
			send_item(CMD_RECORD, $urandom(), cur_now, 1'b0, '0);
		end
	endtask

	task automatic run_random(input bit with_fill);
		int start;
		start = items_sent;
		if (with_fill)
			fill_table();
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 49) == 0)
				fill_table();
			else
				random_item();
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// an unused command may still be in flight
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_PING:    cfg_ping = val[15:0];
			REG_MIN_DLY: cfg_min = val[15:0];
			REG_MAX_DLY: cfg_max = val[15:0];
			default:     cfg_limit = val[5:0];
		endcase
	endtask

	task automatic apply_config(input logic [15:0] ping, input logic [15:0] lo,
			input logic [15:0] hi, input logic [5:0] lim);
		cfg_write(REG_PING, {16'd0, ping});
		cfg_write(REG_MIN_DLY, {16'd0, lo});
		cfg_write(REG_MAX_DLY, {16'd0, hi});
		cfg_write(REG_MAX_RESEND, {26'd0, lim});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// result side back-pressure: free stretches, light stalls, rare long holds
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 40) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(5, 30);
			end else if (stall_pick < 85) begin
				out_stall <= (stall_pick < 60);
				stall_hold = $urandom_range(0, 2);
			end else if (stall_pick < 97) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(3, 8);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(15, 40);
			end
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_seq, kind, last};
			kind_seen[kind]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result seq=%h kind=%0d last=%b",
						$realtime, got.seq, got.kind, got.last);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (got.seq !== want.seq || got.kind !== want.kind
						|| got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp %h/%0d/%b got %h/%0d/%b",
							$realtime, want.seq, want.kind, want.last,
							got.seq, got.kind, got.last);
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		dir_tab = '{
			'{CMD_SCAN,   32'h0,        32'd1000,     1'b1, KIND_NONE_DUE, 32'h0},
			'{CMD_ACK,    32'h0,        32'd1000,     1'b1, KIND_UNKNOWN,  32'h0},
			'{CMD_RECORD, 32'h0,        32'd1000,     1'b1, KIND_RECORDED, 32'h0},
			'{CMD_RECORD, 32'hFFFFFFFF, 32'd1000,     1'b1, KIND_RECORDED, 32'hFFFFFFFF},
			'{CMD_RECORD, 32'hA5A5A5A5, 32'd1100,     1'b1, KIND_RECORDED, 32'hA5A5A5A5},
			// duplicate sequence number
			'{CMD_RECORD, 32'h0,        32'd1200,     1'b1, KIND_RECORDED, 32'h0},
			'{CMD_SCAN,   32'h0,        32'd1500,     1'b1, KIND_NONE_DUE, 32'h0},
			'{CMD_SCAN,   32'h0,        32'd1801,     1'b0, KIND_RESEND,   32'h0},
			// removes only the first of the two
			'{CMD_ACK,    32'h0,        32'd1801,     1'b1, KIND_ACKED,    32'h0},
			'{CMD_SCAN,   32'h0,        32'd2202,     1'b0, KIND_RESEND,   32'h0},
			'{CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, KIND_RESEND,   32'h0},
			'{CMD_ACK,    32'h12345678, 32'd2202,     1'b1, KIND_UNKNOWN,  32'h12345678},
			'{CMD_SCAN,   32'h0,        32'd2202,     1'b1, KIND_NONE_DUE, 32'h0},
			// time runs backwards, elapsed wraps to a huge value
			'{CMD_SCAN,   32'h0,        32'h00000100, 1'b0, KIND_RESEND,   32'h0},
			'{CMD_ACK,    32'hFFFFFFFF, 32'h00000100, 1'b1, KIND_ACKED,    32'hFFFFFFFF},
			'{CMD_ACK,    32'hFFFFFFFF, 32'h00000100, 1'b1, KIND_UNKNOWN,  32'hFFFFFFFF},
			'{CMD_RECORD, 32'h5A5A5A5A, 32'hFFFFFF00, 1'b1, KIND_RECORDED, 32'h5A5A5A5A},
			// forward wrap across zero
			'{CMD_SCAN,   32'h0,        32'h00000400, 1'b0, KIND_RESEND,   32'h0},
			'{CMD_ACK,    32'h0,        32'h00000400, 1'b1, KIND_ACKED,    32'h0},
			'{CMD_ACK,    32'hA5A5A5A5, 32'h00000400, 1'b1, KIND_ACKED,    32'hA5A5A5A5}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r])
			send_item(dir_tab[r].cmd, dir_tab[r].seq, dir_tab[r].tnow, dir_tab[r].typed,
				'{dir_tab[r].tseq, dir_tab[r].tkind, 1'b1});
		cur_now = 32'h00000400;

		drain_results();
		apply_config(16'd50, 16'd250, 16'd5000, 6'd32);
		run_random(1'b1);

		// zero delay, one resend per scan
		drain_results();
		apply_config(16'd0, 16'd0, 16'd0, 6'd1);
		run_random(1'b0);

		drain_results();
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F);
		run_random(1'b1);

		// inverted clamps, scans never resend
		drain_results();
		apply_config(16'($urandom_range(0, 300)), 16'd3000, 16'd100, 6'd0);
		run_random(1'b0);

		drain_results();
		apply_config(16'($urandom_range(1, 200)), 16'($urandom_range(0, 1000)),
			16'($urandom_range(1000, 8000)), 6'($urandom_range(2, 31)));
		run_random(1'b0);

		drain_results();
		$display("items %0d: %0d records, %0d acks, %0d scans, %0d unused, five settings",
			items_sent, cmd_seen[CMD_RECORD], cmd_seen[CMD_ACK], cmd_seen[CMD_SCAN],
			cmd_seen[CMD_UNUSED]);
		$display("seen %0d recorded, %0d full, %0d acked, %0d unknown, %0d resent, %0d idle",
			kind_seen[KIND_RECORDED], kind_seen[KIND_FULL], kind_seen[KIND_ACKED],
			kind_seen[KIND_UNKNOWN], kind_seen[KIND_RESEND], kind_seen[KIND_NONE_DUE]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: reliable_packet_retransmit_tracker_core.f
rtl/rprt_pkg.sv
rtl/rprt_ram.sv
rtl/rprt_ctrl.sv
rtl/rprt_dp.sv
rtl/reliable_packet_retransmit_tracker_core.sv
test/tb_reliable_packet_retransmit_tracker_core.sv
